FILE: rtl/scpg_pkg.sv
// Types and constant codes shared by the sound controller port glue.
package scpg_pkg;

  // Kind of bus request carried by an input item
  typedef enum logic [1:0] {
    ACT_HOST_CMD   = 2'd0,
    ACT_HOST_FLAG  = 2'd1,
    ACT_PORT_WRITE = 2'd2,
    ACT_PORT_READ  = 2'd3
  } action_t;

  // Controller port numbers
  localparam logic [7:0] PORT_LATCH   = 8'h00;
  localparam logic [7:0] PORT_COMMAND = 8'h01;
  localparam logic [7:0] PORT_CONTROL = 8'h02;

  // Control latch codes (low five bits)
  localparam logic [4:0] CTRL_CODE_MASK   = 5'h1f;
  localparam logic [4:0] CTRL_CHIP1_STAT  = 5'h12;
  localparam logic [4:0] CTRL_CHIP0_STAT  = 5'h16;
  localparam logic [4:0] CTRL_HOST_CMD_A  = 5'h0b;
  localparam logic [4:0] CTRL_HOST_CMD_B  = 5'h0f;
  localparam logic [4:0] CTRL_STROBE0     = 5'h15;
  localparam logic [4:0] CTRL_STROBE1     = 5'h11;

  // Value returned by a flag read when the host flag was pending
  localparam logic [7:0] FLAG_READ_VALUE = 8'h40;

  typedef struct packed {
    action_t    action;
    logic [7:0] port;
    logic [7:0] data;
    logic [7:0] chip0_status;
    logic [7:0] chip1_status;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       chip0_strobe;
    logic       chip1_strobe;
    logic [7:0] chip_command_out;
    logic       bank0_load;
    logic [2:0] bank0_index;
    logic       bank1_load;
    logic [2:0] bank1_index;
  } out_item_t;

endpackage

FILE: rtl/scpg_if.sv
// Valid/ready channel interfaces for input requests and result requests.
interface scpg_in_if import scpg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface scpg_out_if import scpg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/sound_controller_port_glue.sv
// Port glue between host, sound controller and two sample chips.
//
//  channel   direction  handshake            payload
//  in_ch     sink       valid/ready          action, port, data, chip statuses
//  out_ch    source     valid/ready          read data, strobes, bank loads
//
// One request per cycle: an input register feeds the decode logic, which loads
// the result register and updates the latches on the same edge.
// A request is held in the input register, then in the result register, where
// it stays valid until it is taken.
// Synchronous active-low reset clears all latches and both stage valids.
// A stalled result holds the pipeline; the input register still accepts
// while it is empty or the result register is free or being drained.
module sound_controller_port_glue
  import scpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  scpg_in_if.sink     in_ch,
  scpg_out_if.source  out_ch
);

  logic      in_valid_r;
  in_item_t  in_pay_r;
  logic      out_valid_r;
  out_item_t out_pay_r;
  out_item_t out_pay_nxt;

  logic [7:0] host_command_r, host_command_nxt;
  logic       host_flag_r, host_flag_nxt;
  logic [7:0] port_latch_r, port_latch_nxt;
  logic [7:0] control_latch_r, control_latch_nxt;
  logic [7:0] chip_cmd_r, chip_cmd_nxt;
  logic [2:0] bank0_r, bank0_nxt;
  logic [2:0] bank1_r, bank1_nxt;

  logic       out_adv;
  logic       out_load;
  logic [2:0] nb0;
  logic [2:0] nb1;
  logic [4:0] ctrl_code;
  logic [4:0] data_code;

  // Advance when the result register is empty or being taken
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign out_load    = out_adv && in_valid_r;
  assign in_ch.ready = !in_valid_r || out_adv;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_pay_r;

  assign ctrl_code = control_latch_r[4:0] & CTRL_CODE_MASK;
  assign data_code = in_pay_r.data[4:0] & CTRL_CODE_MASK;
  assign nb0 = {in_pay_r.data[7], port_latch_r[3:2]};
  assign nb1 = {in_pay_r.data[5], port_latch_r[1:0]};

  // Decode the registered request against the latches
  always_comb begin
    host_command_nxt  = host_command_r;
    host_flag_nxt     = host_flag_r;
    port_latch_nxt    = port_latch_r;
    control_latch_nxt = control_latch_r;
    chip_cmd_nxt      = chip_cmd_r;
    bank0_nxt         = bank0_r;
    bank1_nxt         = bank1_r;
    out_pay_nxt       = '0;

    case (in_pay_r.action)
      ACT_HOST_CMD: begin
        host_command_nxt = in_pay_r.data;
      end
      ACT_HOST_FLAG: begin
        host_flag_nxt = 1'b1;
      end
      ACT_PORT_WRITE: begin
        if (in_pay_r.port == PORT_LATCH) begin
          port_latch_nxt = in_pay_r.data;
        end else if (in_pay_r.port == PORT_COMMAND) begin
          chip_cmd_nxt = in_pay_r.data;
        end else if (in_pay_r.port == PORT_CONTROL) begin
          control_latch_nxt = in_pay_r.data;
          // Report bank changes; chip 0 index is one below the bank, floored at zero
          if (nb0 != bank0_r) begin
            bank0_nxt               = nb0;
            out_pay_nxt.bank0_load  = 1'b1;
            out_pay_nxt.bank0_index = (nb0 != 3'd0) ? nb0 - 3'd1 : 3'd0;
          end
          if (nb1 != bank1_r) begin
            bank1_nxt               = nb1;
            out_pay_nxt.bank1_load  = 1'b1;
            out_pay_nxt.bank1_index = nb1;
          end
          // Strobe the command byte into one chip
          if (data_code == CTRL_STROBE0) begin
            out_pay_nxt.chip0_strobe     = 1'b1;
            out_pay_nxt.chip_command_out = chip_cmd_r;
          end else if (data_code == CTRL_STROBE1) begin
            out_pay_nxt.chip1_strobe     = 1'b1;
            out_pay_nxt.chip_command_out = chip_cmd_r;
          end
        end
      end
      ACT_PORT_READ: begin
        if (in_pay_r.port == PORT_LATCH) begin
          out_pay_nxt.read_data = port_latch_r;
        end else if (in_pay_r.port == PORT_COMMAND) begin
          case (ctrl_code) inside
            CTRL_CHIP1_STAT: out_pay_nxt.read_data = {4'h0, in_pay_r.chip1_status[3:0]};
            CTRL_CHIP0_STAT: out_pay_nxt.read_data = {4'h0, in_pay_r.chip0_status[3:0]};
            CTRL_HOST_CMD_A, CTRL_HOST_CMD_B: out_pay_nxt.read_data = host_command_r;
            default: out_pay_nxt.read_data = '0;
          endcase
        end else if (in_pay_r.port == PORT_CONTROL) begin
          // Read and clear the pending host flag
          if (host_flag_r) begin
            host_flag_nxt         = 1'b0;
            out_pay_nxt.read_data = FLAG_READ_VALUE;
          end
        end
      end
      default: begin
        out_pay_nxt = '0;
      end
    endcase
  end

  // Input register: take a request whenever ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_pay_r <= in_ch.payload;
    end
  end

  // Result register and latch update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      host_command_r  <= '0;
      host_flag_r     <= 1'b0;
      port_latch_r    <= '0;
      control_latch_r <= '0;
      chip_cmd_r      <= '0;
      bank0_r         <= '0;
      bank1_r         <= '0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        host_command_r  <= host_command_nxt;
        host_flag_r     <= host_flag_nxt;
        port_latch_r    <= port_latch_nxt;
        control_latch_r <= control_latch_nxt;
        chip_cmd_r      <= chip_cmd_nxt;
        bank0_r         <= bank0_nxt;
        bank1_r         <= bank1_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pay_r <= out_pay_nxt;
    end
  end

`ifndef SYNTH
  a_strobe_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_pay_r.chip0_strobe && out_pay_r.chip1_strobe))
    else $error("both chip strobes set in one result");

  a_bank1_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (!out_pay_r.bank1_load || out_pay_r.bank1_index == bank1_r))
    else $error("reported bank 1 index differs from bank register");

  a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && in_pay_r.action == ACT_PORT_READ && in_pay_r.port == PORT_CONTROL)
      |=> !host_flag_r)
    else $error("host flag not cleared by flag read");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r))
    else $error("input stalled with a free stage");
`endif

endmodule
